// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the port checker file.
// ----------------------------------------------------------------------------
// Each macro places one labeled concurrent assertion, clocked on the rising
// edge and disabled while the asynchronous reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property text holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg
// Codes, header characters, register indexes and parser phase type for the frame parser.
// ----------------------------------------------------------------------------
package msp_pkg;

	// header characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	// event codes on event_res
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_DATA = 3'd1;
	localparam logic [2:0] EV_GOOD = 3'd2;
	localparam logic [2:0] EV_FAIL = 3'd3;
	localparam logic [2:0] EV_BAD  = 3'd4;

	// header phase reported with EV_BAD
	localparam logic [1:0] HP_DOLLAR = 2'd0;
	localparam logic [1:0] HP_M      = 2'd1;
	localparam logic [1:0] HP_GT     = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_3      = 3'd4;

	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd64;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_GOT_D,
		PH_GOT_M,
		PH_SIZE,
		PH_CMD,
		PH_FILL,
		PH_CHECK,
		PH_SKIP
	} phase_t;

endpackage

// ----- hw/rtl/msp_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// msp_frame_parser_core
// Reply-frame deframer for the v1 serial protocol: '$' 'M' '>' size command
// payload checksum, one received byte in, one event out per byte.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | byte_in
//  result   | out_valid / out_ready  | event_res command_id data_byte byte_index
//           |                        | frame_size header_phase last
//  config   | cfg_we (no wait)       | cfg_index cfg_data
//
//  Every accepted byte yields exactly one result transfer, event none included.
//  A byte passes the byte register (_s1), then the parse logic writes the
//  result register (_s2) and the parser state in the same edge.
//  Throughput is one byte per cycle while the result is not stalled; the
//  single state update per byte is the only loop.
//  A stalled result holds both stages; in_ready drops only when both are full.
//  Reset: parser hunts for '$', max_payload is 64, the interest mask is clear.
//
module msp_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  command_id,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [7:0]  frame_size,
	output logic [1:0]  header_phase,
	output logic        last,

	input  logic                            cfg_we,
	input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data
);

	// configuration
	logic [7:0]   max_payload_q;
	logic [255:0] interest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= msp_pkg::MAX_PAYLOAD_RST;
			interest_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				msp_pkg::REG_MAX_PAYLOAD: max_payload_q      <= cfg_data[7:0];
				msp_pkg::REG_MASK_0:      interest_q[63:0]    <= cfg_data;
				msp_pkg::REG_MASK_1:      interest_q[127:64]  <= cfg_data;
				msp_pkg::REG_MASK_2:      interest_q[191:128] <= cfg_data;
				msp_pkg::REG_MASK_3:      interest_q[255:192] <= cfg_data;
				default: ; // unmapped index, dropped
			endcase
		end
	end

	// pipeline control
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       adv_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
		end
	end

	// parser state
	msp_pkg::phase_t phase_q, phase_d;
	logic [7:0] size_q, size_d;
	logic [7:0] cmd_q, cmd_d;
	logic [8:0] count_q, count_d;
	logic [7:0] xor_q, xor_d;

	// result of the byte in stage 1
	logic [2:0] ev_d;
	logic [7:0] rcmd_d, rdata_d, ridx_d, rsize_d;
	logic [1:0] rhp_d;
	logic       rlast_d;

	logic [8:0] count_inc;
	logic       kept;
	logic [7:0] chk;

	assign count_inc = count_q + 9'd1;
	assign kept      = interest_q[byte_s1];
	assign chk       = xor_q ^ byte_s1;

	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		cmd_d   = cmd_q;
		count_d = count_q;
		xor_d   = xor_q;
		ev_d    = msp_pkg::EV_NONE;
		rcmd_d  = '0;
		rdata_d = '0;
		ridx_d  = '0;
		rsize_d = '0;
		rhp_d   = msp_pkg::HP_DOLLAR;
		rlast_d = 1'b0;
		case (phase_q)
			msp_pkg::PH_HUNT: begin
				if (byte_s1 == msp_pkg::CH_DOLLAR) begin
					phase_d = msp_pkg::PH_GOT_D;
				end else begin
					ev_d    = msp_pkg::EV_BAD;
					rdata_d = byte_s1;
					rhp_d   = msp_pkg::HP_DOLLAR;
				end
			end
			msp_pkg::PH_GOT_D: begin
				if (byte_s1 == msp_pkg::CH_M) begin
					phase_d = msp_pkg::PH_GOT_M;
				end else begin
					ev_d    = msp_pkg::EV_BAD;
					rdata_d = byte_s1;
					rhp_d   = msp_pkg::HP_M;
					phase_d = msp_pkg::PH_HUNT;
				end
			end
			msp_pkg::PH_GOT_M: begin
				if (byte_s1 == msp_pkg::CH_GT) begin
					phase_d = msp_pkg::PH_SIZE;
				end else begin
					ev_d    = msp_pkg::EV_BAD;
					rdata_d = byte_s1;
					rhp_d   = msp_pkg::HP_GT;
					phase_d = msp_pkg::PH_HUNT;
				end
			end
			msp_pkg::PH_SIZE: begin
				// oversized frame: silent drop, resync on the next byte
				if (byte_s1 > max_payload_q) begin
					phase_d = msp_pkg::PH_HUNT;
				end else begin
					size_d  = byte_s1;
					xor_d   = byte_s1;
					phase_d = msp_pkg::PH_CMD;
				end
			end
			msp_pkg::PH_CMD: begin
				count_d = '0;
				cmd_d   = byte_s1;
				xor_d   = chk;
				if (!kept) begin
					phase_d = msp_pkg::PH_SKIP;
				end else if (size_q == 8'd0) begin
					phase_d = msp_pkg::PH_CHECK;  // empty frame: checksum next
				end else begin
					phase_d = msp_pkg::PH_FILL;
				end
			end
			msp_pkg::PH_FILL: begin
				ev_d    = msp_pkg::EV_DATA;
				rcmd_d  = cmd_q;
				rdata_d = byte_s1;
				ridx_d  = count_q[7:0];
				rsize_d = size_q;
				count_d = count_inc;
				xor_d   = chk;
				if (count_inc >= {1'b0, size_q}) begin
					phase_d = msp_pkg::PH_CHECK;
				end
			end
			msp_pkg::PH_CHECK: begin
				ev_d    = (chk != 8'd0) ? msp_pkg::EV_FAIL : msp_pkg::EV_GOOD;
				rcmd_d  = cmd_q;
				rdata_d = byte_s1;
				rsize_d = size_q;
				rlast_d = 1'b1;
				phase_d = msp_pkg::PH_HUNT;
			end
			msp_pkg::PH_SKIP: begin
				// payload plus checksum swallowed without events
				if (count_q >= {1'b0, size_q}) begin
					phase_d = msp_pkg::PH_HUNT;
				end
				count_d = count_inc;
			end
			default: begin
				phase_d = msp_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msp_pkg::PH_HUNT;
			size_q  <= '0;
			cmd_q   <= '0;
			count_q <= '0;
			xor_q   <= '0;
		end else if (adv_s1) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			cmd_q   <= cmd_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

	// result register
	logic [2:0] ev_s2;
	logic [7:0] cmd_s2, data_s2, idx_s2, size_s2;
	logic [1:0] hp_s2;
	logic       last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ev_s2   <= ev_d;
			cmd_s2  <= rcmd_d;
			data_s2 <= rdata_d;
			idx_s2  <= ridx_d;
			size_s2 <= rsize_d;
			hp_s2   <= rhp_d;
			last_s2 <= rlast_d;
		end
	end

	assign out_valid    = valid_s2;
	assign event_res    = ev_s2;
	assign command_id   = cmd_s2;
	assign data_byte    = data_s2;
	assign byte_index   = idx_s2;
	assign frame_size   = size_s2;
	assign header_phase = hp_s2;
	assign last         = last_s2;

endmodule

// ----- hw/rtl/msp_checker.sv -----
// ----------------------------------------------------------------------------
// msp_checker
// Port-level assertions for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [7:0]  byte_index,
	input logic [7:0]  frame_size,
	input logic [1:0]  header_phase,
	input logic        last
);

	logic ends_frame;
	logic hp_set;
	logic bad_ev;
	logic data_ev;
	logic out_stall;
	logic can_take;

	assign ends_frame = (event_res == msp_pkg::EV_GOOD) || (event_res == msp_pkg::EV_FAIL);
	assign hp_set     = out_valid && (header_phase != msp_pkg::HP_DOLLAR);
	assign bad_ev     = (event_res == msp_pkg::EV_BAD);
	assign data_ev    = out_valid && (event_res == msp_pkg::EV_DATA);
	assign out_stall  = out_valid && !out_ready;
	// result side free: the byte stage can always move on
	assign can_take   = !out_valid || out_ready;

	`ASSERT_IMPLIES(a_last_ends, clk, arst_n, out_valid, last == ends_frame, "last mismatch")
	`ASSERT_IMPLIES(a_hp_bad, clk, arst_n, hp_set, bad_ev, "header_phase off event")
	`ASSERT_IMPLIES(a_idx_range, clk, arst_n, data_ev, byte_index < frame_size, "index beyond size")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(event_res), "stall lost")
	`ASSERT_IMPLIES(a_in_ready, clk, arst_n, can_take, in_ready, "input blocked without stall")

endmodule

bind msp_frame_parser_core msp_checker u_msp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.event_res    (event_res),
	.byte_index   (byte_index),
	.frame_size   (frame_size),
	.header_phase (header_phase),
	.last         (last)
);

// ----- dv/msp_frame_parser_checker.sv -----
// ----------------------------------------------------------------------------
// msp_frame_parser_checker
// Watches the byte, result and config ports of the frame parser, predicts the
// event for every accepted byte and compares each result transfer in order.
// ----------------------------------------------------------------------------
module msp_frame_parser_checker (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    byte_in,

	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [2:0]                    event_res,
	input  logic [7:0]                    command_id,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    byte_index,
	input  logic [7:0]                    frame_size,
	input  logic [1:0]                    header_phase,
	input  logic                          last,

	input  logic                          cfg_we,
	input  logic [msp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,

	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] ev;
		logic [7:0] cmd;
		logic [7:0] data;
		logic [7:0] idx;
		logic [7:0] size;
		logic [1:0] hp;
		logic       last;
	} parse_result_t;

	parse_result_t expected_events[$];
	int            mismatches = 0;
	int            waiting = 0;

	// predicted parser state and settings
	msp_pkg::phase_t ph;
	logic [7:0]      frame_len;
	logic [7:0]      frame_cmd;
	logic [7:0]      frame_xor;
	logic [8:0]      fill_count;
	logic [7:0]      max_len;
	logic [255:0]    interest;

	assign fail_count = mismatches;
	assign pending    = waiting;

	function automatic parse_result_t deframe_byte(input logic [7:0] b);
		parse_result_t r;
		r = '0;
		case (ph)
			msp_pkg::PH_HUNT: begin
				if (b == msp_pkg::CH_DOLLAR)
					ph = msp_pkg::PH_GOT_D;
				else begin
					r.ev = msp_pkg::EV_BAD; r.data = b; r.hp = msp_pkg::HP_DOLLAR;
				end
			end
			msp_pkg::PH_GOT_D: begin
				if (b == msp_pkg::CH_M)
					ph = msp_pkg::PH_GOT_M;
				else begin
					r.ev = msp_pkg::EV_BAD; r.data = b; r.hp = msp_pkg::HP_M;
					ph = msp_pkg::PH_HUNT;
				end
			end
			msp_pkg::PH_GOT_M: begin
				if (b == msp_pkg::CH_GT)
					ph = msp_pkg::PH_SIZE;
				else begin
					r.ev = msp_pkg::EV_BAD; r.data = b; r.hp = msp_pkg::HP_GT;
					ph = msp_pkg::PH_HUNT;
				end
			end
			msp_pkg::PH_SIZE: begin
				// oversized frames vanish without an event
				if (b > max_len)
					ph = msp_pkg::PH_HUNT;
				else begin
					frame_len = b; frame_xor = b; ph = msp_pkg::PH_CMD;
				end
			end
			msp_pkg::PH_CMD: begin
				fill_count = '0;
				frame_cmd  = b;
				frame_xor  = frame_xor ^ b;
				if (!interest[b])
					ph = msp_pkg::PH_SKIP;
				else if (frame_len == 8'd0)
					ph = msp_pkg::PH_CHECK;
				else
					ph = msp_pkg::PH_FILL;
			end
			msp_pkg::PH_FILL: begin
				r.ev = msp_pkg::EV_DATA; r.cmd = frame_cmd; r.data = b;
				r.idx = fill_count[7:0]; r.size = frame_len;
				fill_count = fill_count + 9'd1;
				frame_xor  = frame_xor ^ b;
				if (fill_count >= {1'b0, frame_len})
					ph = msp_pkg::PH_CHECK;
			end
			msp_pkg::PH_CHECK: begin
				r.ev   = ((frame_xor ^ b) != 8'd0) ? msp_pkg::EV_FAIL : msp_pkg::EV_GOOD;
				r.cmd  = frame_cmd; r.data = b; r.size = frame_len; r.last = 1'b1;
				ph     = msp_pkg::PH_HUNT;
			end
			default: begin
				// skipped command: payload plus checksum, all silent
				if (fill_count >= {1'b0, frame_len})
					ph = msp_pkg::PH_HUNT;
				fill_count = fill_count + 9'd1;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", what, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			expected_events.delete();
			ph         = msp_pkg::PH_HUNT;
			frame_len  = '0;
			frame_cmd  = '0;
			frame_xor  = '0;
			fill_count = '0;
			max_len    = msp_pkg::MAX_PAYLOAD_RST;
			interest   = '0;
			waiting   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					msp_pkg::REG_MAX_PAYLOAD: max_len = cfg_data[7:0];
					msp_pkg::REG_MASK_0:      interest[63:0]    = cfg_data;
					msp_pkg::REG_MASK_1:      interest[127:64]  = cfg_data;
					msp_pkg::REG_MASK_2:      interest[191:128] = cfg_data;
					msp_pkg::REG_MASK_3:      interest[255:192] = cfg_data;
					default:                  ;
				endcase
			end
			if (in_valid && in_ready)
				expected_events.push_back(deframe_byte(byte_in));
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0)
					report_mismatch($sformatf("result transfer with no byte pending, event %0d",
						event_res));
				else begin
					want = expected_events.pop_front();
					check_field("event_res", 8'(event_res), 8'(want.ev));
					check_field("command_id", command_id, want.cmd);
					check_field("data_byte", data_byte, want.data);
					check_field("byte_index", byte_index, want.idx);
					check_field("frame_size", frame_size, want.size);
					check_field("header_phase", 8'(header_phase), 8'(want.hp));
					check_field("last", 8'(last), 8'(want.last));
				end
			end
			waiting <= expected_events.size();
		end
	end

endmodule

// ----- dv/msp_frame_parser_core_test.sv -----
// ----------------------------------------------------------------------------
// msp_frame_parser_core_test
// Drives bytes into the frame parser: a directed pass over header errors,
// empty, failing, oversized and skipped frames, then random frame traffic
// under several register settings and idle/stall mixes. The checker beside
// the DUT predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module msp_frame_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any transfer before the run is declared hung
	localparam int IDLE_LIMIT  = 2000;
	// long receiver hold-off so the pipeline fills and in_ready drops
	localparam int HOLD_CYCLES = 300;

	// index past the last register: writes must be ignored
	localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

	// commands used by the directed pass
	localparam logic [7:0] CMD_KEPT_LO = 8'd0;    // mask 0, bit 0
	localparam logic [7:0] CMD_KEPT_HI = 8'd255;  // mask 3, bit 63
	localparam logic [7:0] CMD_SKIPPED = 8'd100;  // mask 1, bit 36

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    byte_in;
	logic                          out_valid;
	logic                          out_ready;
	logic [2:0]                    event_res;
	logic [7:0]                    command_id;
	logic [7:0]                    data_byte;
	logic [7:0]                    byte_index;
	logic [7:0]                    frame_size;
	logic [1:0]                    header_phase;
	logic                          last;
	logic                          cfg_we;
	logic [msp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0]                   cfg_data;

	int                            fail_count;
	int                            pending;

	// stimulus knobs, shared with the receiver process
	int                            idle_pct  = 0;
	int                            stall_pct = 0;
	logic                          hold_req  = 1'b0;
	int                            bytes_sent = 0;
	logic [7:0]                    cur_max = msp_pkg::MAX_PAYLOAD_RST;

	msp_frame_parser_core dut (.*);

	msp_frame_parser_checker chk (.*);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// One byte transfer; valid stays up afterwards so back-to-back bytes
	// need no extra edge. Random idle cycles go in front of the byte.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [7:0] sz, input logic [7:0] cmd);
		send_byte(msp_pkg::CH_DOLLAR);
		send_byte(msp_pkg::CH_M);
		send_byte(msp_pkg::CH_GT);
		send_byte(sz);
		send_byte(cmd);
	endtask

	// Well-formed frame with random content. Sizes mostly small, a few up to
	// the limit, some just over it (silent drop), checksum right most of the time.
	task automatic send_frame;
		int         r;
		logic [7:0] sz;
		logic [7:0] cmd;
		logic [7:0] sum;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 85)
			sz = 8'($urandom_range((cur_max < 8'd6) ? cur_max : 8'd6));
		else if (r < 91)
			sz = 8'($urandom_range(cur_max));
		else if (r < 96)
			sz = (cur_max == 8'hFF) ? 8'hFF : cur_max + 8'd1;
		else
			sz = 8'($urandom_range(255));
		cmd = 8'($urandom_range(255));
		send_header(sz, cmd);
		sum = sz ^ cmd;
		repeat (sz) begin
			b   = 8'($urandom_range(255));
			sum = sum ^ b;
			send_byte(b);
		end
		send_byte(($urandom_range(99) < 80) ? sum : 8'($urandom_range(255)));
	endtask

	// line noise and broken headers; a truncated frame lets the next
	// header land inside its payload
	task automatic send_noise;
		case ($urandom_range(3))
			0: send_byte(8'($urandom_range(255)));
			1: begin
				send_byte(msp_pkg::CH_DOLLAR);
				send_byte(8'($urandom_range(255)));
			end
			2: begin
				send_byte(msp_pkg::CH_DOLLAR);
				send_byte(msp_pkg::CH_M);
				send_byte(8'($urandom_range(255)));
			end
			default: send_header(8'($urandom_range(8)), 8'($urandom_range(255)));
		endcase
	endtask

	task automatic run_traffic(input int n, input int idle, input int stall);
		int target;
		target    = bytes_sent + n;
		idle_pct  = idle;
		stall_pct = stall;
		while (bytes_sent < target) begin
			if ($urandom_range(99) < 75)
				send_frame();
			else
				send_noise();
		end
	endtask

	// drop valid and wait for every predicted result to come back
	task automatic wait_drained;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// register writes, only while the parser is drained
	// ------------------------------------------------------------------

	task automatic write_reg(input logic [msp_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] max_len, input logic [63:0] m0,
		input logic [63:0] m1, input logic [63:0] m2, input logic [63:0] m3);
		write_reg(msp_pkg::REG_MAX_PAYLOAD, {56'd0, max_len});
		write_reg(msp_pkg::REG_MASK_0, m0);
		write_reg(msp_pkg::REG_MASK_1, m1);
		write_reg(msp_pkg::REG_MASK_2, m2);
		write_reg(msp_pkg::REG_MASK_3, m3);
		cur_max = max_len;
	endtask

	// ------------------------------------------------------------------
	// receiver side: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		logic held;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held       = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// watchdog: any transfer on either channel restarts the count
	// ------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("msp_frame_parser_core test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] directed_bytes[$];
		// header errors at each stage, empty kept frame with good checksum,
		// one-byte kept frame with bad checksum, oversized size byte followed
		// by a noise byte, empty skipped frame
		directed_bytes = '{
			msp_pkg::CH_DOLLAR, 8'h41,
			msp_pkg::CH_DOLLAR, msp_pkg::CH_M, 8'h3C,
			msp_pkg::CH_DOLLAR, msp_pkg::CH_M, msp_pkg::CH_GT,
			8'h00, CMD_KEPT_HI, CMD_KEPT_HI,
			msp_pkg::CH_DOLLAR, msp_pkg::CH_M, msp_pkg::CH_GT,
			8'h01, CMD_KEPT_LO, 8'hAA, 8'h00,
			msp_pkg::CH_DOLLAR, msp_pkg::CH_M, msp_pkg::CH_GT,
			8'hFF, 8'h00,
			msp_pkg::CH_DOLLAR, msp_pkg::CH_M, msp_pkg::CH_GT,
			8'h00, CMD_SKIPPED, 8'h64
		};

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		byte_in   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass, no idling
		configure(msp_pkg::MAX_PAYLOAD_RST,
			{$urandom, $urandom} | 64'h1,
			{$urandom, $urandom} & ~(64'h1 << CMD_SKIPPED[5:0]),
			{$urandom, $urandom},
			{$urandom, $urandom} | (64'h1 << 63));
		write_reg(REG_UNUSED, {$urandom, $urandom});
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		wait_drained();

		// widest limit, everything kept, no idling; receiver holds off once
		configure(8'hFF, '1, '1, '1, '1);
		hold_req = 1'b1;
		run_traffic(100, 0, 0);
		wait_drained();

		// small limit, random mask, sender idles
		configure(8'd8, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_traffic(80, 62, 0);
		wait_drained();

		// mid limit, mixed mask, receiver stalls
		configure(8'd20, {$urandom, $urandom}, '0, {$urandom, $urandom}, '1);
		run_traffic(80, 0, 62);
		wait_drained();

		// zero limit: only empty frames survive
		configure(8'd0, '1, '1, '1, '1);
		run_traffic(60, 15, 15);
		wait_drained();

		// nothing kept: every frame skipped silently
		configure(msp_pkg::MAX_PAYLOAD_RST, '0, '0, '0, '0);
		run_traffic(50, 15, 15);
		wait_drained();

		if (fail_count == 0)
			$display("msp_frame_parser_core test passed");
		else
			$display("msp_frame_parser_core test failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/msp_pkg.sv
hw/rtl/msp_frame_parser_core.sv
hw/rtl/msp_checker.sv
dv/msp_frame_parser_checker.sv
dv/msp_frame_parser_core_test.sv
